// ===== rtl/msct_pkg.sv =====
// shared types and constants for the multi-slot compare timer
package msct_pkg;

    localparam int TICK_W   = 32;
    localparam int SCALE_W  = 4;
    localparam int ID_W     = 3;
    localparam int MASK_W   = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

    // register index, taken from paddr above the byte offset
    localparam logic REG_TIME_SCALE = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_ACK   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               opcode;
        logic [ID_W-1:0]   slot_id;
        logic [TICK_W-1:0] span;
        logic              periodic;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   assigned_id;
        logic [MASK_W-1:0] done_mask;
        logic [MASK_W-1:0] running_mask;
    } result_t;

endpackage

// ===== rtl/msct_slot_bank.sv =====
// slot state, tick counter and command execution, next state registered on exec
module msct_slot_bank #(
    parameter int SLOTS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             exec,
    input  msct_pkg::cmd_t   cmd,
    output msct_pkg::result_t result
);

    logic [msct_pkg::TICK_W-1:0] tick_count_reg;
    logic [msct_pkg::TICK_W-1:0] tick_count_next;
    logic [msct_pkg::TICK_W-1:0] compare_reg [SLOTS];
    logic [msct_pkg::TICK_W-1:0] compare_next [SLOTS];
    logic [msct_pkg::TICK_W-1:0] reload_reg [SLOTS];
    logic [msct_pkg::TICK_W-1:0] reload_next [SLOTS];
    logic [msct_pkg::TICK_W-1:0] start_compare;
    logic [SLOTS-1:0]            flag_reg;
    logic [SLOTS-1:0]            flag_next;
    logic [SLOTS-1:0]            running_reg;
    logic [SLOTS-1:0]            running_next;
    logic [SLOTS-1:0]            done_reg;
    logic [SLOTS-1:0]            done_next;
    logic [SLOTS-1:0]            hits;
    logic [msct_pkg::MASK_W+SLOTS-1:0] done_wide;
    logic [msct_pkg::MASK_W+SLOTS-1:0] running_wide;
    logic                        found;
    logic                        slot_ok;
    logic [msct_pkg::ID_W-1:0]   assigned;

    assign slot_ok = (cmd.slot_id != '0) && (cmd.slot_id <= msct_pkg::ID_W'(SLOTS));
    assign start_compare = tick_count_reg + cmd.span;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        compare_next    = compare_reg;
        reload_next     = reload_reg;
        flag_next       = flag_reg;
        running_next    = running_reg;
        done_next       = done_reg;
        hits            = '0;
        found           = 1'b0;
        assigned        = '0;
        case (cmd.opcode)
            msct_pkg::OP_TICK:
            begin
                tick_count_next = tick_count_reg + 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    hits[i] = running_reg[i] && (compare_reg[i] == tick_count_next);
                end
                done_next = (done_reg | hits) & running_reg;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (hits[i])
                    begin
                        if (flag_reg[i])
                        begin
                            compare_next[i] = compare_reg[i] + reload_reg[i];
                        end
                        else
                        begin
                            running_next[i] = 1'b0;
                        end
                    end
                end
            end
            msct_pkg::OP_START:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !running_reg[i])
                    begin
                        found           = 1'b1;
                        running_next[i] = 1'b1;
                        done_next[i]    = 1'b0;
                        flag_next[i]    = cmd.periodic;
                        reload_next[i]  = cmd.span;
                        compare_next[i] = start_compare;
                        assigned        = msct_pkg::ID_W'(i + 1);
                    end
                end
            end
            msct_pkg::OP_STOP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_ok && cmd.slot_id == msct_pkg::ID_W'(i + 1))
                    begin
                        running_next[i] = 1'b0;
                    end
                end
            end
            msct_pkg::OP_ACK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_ok && cmd.slot_id == msct_pkg::ID_W'(i + 1))
                    begin
                        done_next[i] = 1'b0;
                    end
                end
            end
            default:
            begin
                tick_count_next = tick_count_reg;
            end
        endcase
    end

    // masks are cut or zero-filled to the fixed result width
    assign done_wide    = {{msct_pkg::MASK_W{1'b0}}, done_next};
    assign running_wide = {{msct_pkg::MASK_W{1'b0}}, running_next};

    assign result.assigned_id  = assigned;
    assign result.done_mask    = done_wide[msct_pkg::MASK_W-1:0];
    assign result.running_mask = running_wide[msct_pkg::MASK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            flag_reg       <= '0;
            running_reg    <= '0;
            done_reg       <= '0;
        end
        else if (exec)
        begin
            tick_count_reg <= tick_count_next;
            flag_reg       <= flag_next;
            running_reg    <= running_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            compare_reg <= compare_next;
            reload_reg  <= reload_next;
        end
    end

endmodule

// ===== rtl/multi_slot_compare_timer.sv =====
// top level: apb register, input stage, slot bank and result register
// path: the command is held in the input stage register, then the slot bank result is registered
// throughput: one item per cycle unless out_ready holds a valid result, the slot bank executes one command per cycle
// the start span period * time_scale is formed in the input stage
// reset: counter, running, done and reload flags cleared, time_scale set to 1
module multi_slot_compare_timer #(
    parameter int SLOTS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msct_pkg::APB_AW-1:0]   paddr,
    input  logic [msct_pkg::APB_DW-1:0]   pwdata,
    output logic [msct_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [msct_pkg::ID_W-1:0]     slot_id,
    input  logic [msct_pkg::TICK_W-1:0]   period,
    input  logic                          periodic,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msct_pkg::ID_W-1:0]     assigned_id,
    output logic [msct_pkg::MASK_W-1:0]   done_mask,
    output logic [msct_pkg::MASK_W-1:0]   running_mask
);

    logic [msct_pkg::SCALE_W-1:0] time_scale_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    msct_pkg::cmd_t               cmd_reg;
    msct_pkg::cmd_t               cmd_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    msct_pkg::result_t            result_reg;
    msct_pkg::result_t            bank_result;
    logic                         exec;
    logic                         in_xfer;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == msct_pkg::REG_TIME_SCALE);
    assign prdata    = (paddr[2] == msct_pkg::REG_TIME_SCALE)
                     ? {{(msct_pkg::APB_DW-msct_pkg::SCALE_W){1'b0}}, time_scale_reg}
                     : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_scale_reg <= msct_pkg::SCALE_RESET;
        end
        else if (cfg_write)
        begin
            time_scale_reg <= pwdata[msct_pkg::SCALE_W-1:0];
        end
    end

    assign exec     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || exec;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        cmd_next.opcode   = msct_pkg::op_t'(opcode);
        cmd_next.slot_id  = slot_id;
        cmd_next.span     = msct_pkg::TICK_W'(period * msct_pkg::TICK_W'(time_scale_reg));
        cmd_next.periodic = periodic;
        s1_valid_next     = in_xfer || (s1_valid_reg && !exec);
        out_valid_next    = exec || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= cmd_next;
        end
        if (exec)
        begin
            result_reg <= bank_result;
        end
    end

    msct_slot_bank #(
        .SLOTS (SLOTS)
    ) u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .cmd    (cmd_reg),
        .result (bank_result)
    );

    assign out_valid    = out_valid_reg;
    assign assigned_id  = result_reg.assigned_id;
    assign done_mask    = result_reg.done_mask;
    assign running_mask = result_reg.running_mask;

    // a granted slot id never exceeds the bank size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (assigned_id <= msct_pkg::ID_W'(SLOTS)))
    else $error("assigned id beyond slot count");

    // a granted slot within the mask width shows as running in the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned_id != '0 && assigned_id <= msct_pkg::ID_W'(msct_pkg::MASK_W)
        |-> ((running_mask >> (assigned_id - 1'b1)) & 1'b1) != '0)
    else $error("assigned slot not running");

    // a stalled input stage always holds a pending command
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
    else $error("input stalled without backpressure");

    // non-start commands always give a zero id
    assert property (@(posedge clk) disable iff (!rst_n)
        exec && cmd_reg.opcode != msct_pkg::OP_START |=> assigned_id == '0)
    else $error("id given by non-start command");

endmodule
